FILE: rtl/plsl_pkg.sv
package plsl_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic signed [17:0] ALPHA_ONE = 18'sd65536;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic REG_KEY_COUNT = 1'b0;
    localparam logic REG_WRAP_MODE = 1'b1;

    // classified word handed from front to back
    typedef struct packed {
        logic        lookup;
        logic [5:0]  index;
        logic [31:0] value;
    } plsl_cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RD0,
        BK_RDL,
        BK_CHK,
        BK_SRD,
        BK_SCMP,
        BK_DIV,
        BK_RES
    } plsl_state_t;

endpackage

FILE: rtl/plsl_front.sv
module plsl_front
    import plsl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic              opcode,
    input  logic [5:0]        key_index,
    input  logic signed [31:0] key_value,
    input  logic signed [31:0] lookup_key,
    output logic              cmd_valid,
    input  logic              cmd_take,
    output plsl_cmd_t         cmd
);

    plsl_cmd_t   fifo_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;
    plsl_cmd_t   cmd_in;

    // classify: a lookup carries its key, a write carries the new table key
    always_comb
    begin
        cmd_in.lookup = (opcode == OP_LOOKUP);
        cmd_in.index  = key_index;
        cmd_in.value  = (opcode == OP_LOOKUP) ? lookup_key : key_value;
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: rtl/plsl_divider.sv
module plsl_divider
    import plsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] offset,
    input  logic signed [32:0] span,
    output logic               done,
    output logic signed [17:0] alpha
);

    logic               prep_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               neg_reg;
    logic               zero_reg;
    logic [32:0]        mag_reg;
    logic [32:0]        span_reg;
    logic [32:0]        rem_reg;
    logic [15:0]        q_reg;
    logic [4:0]         cnt_reg;
    logic signed [17:0] alpha_reg;
    logic [33:0]        rem_shift;
    logic               fits;

    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = (rem_shift >= {1'b0, span_reg});
    assign done      = done_reg;
    assign alpha     = alpha_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            prep_reg <= start;
            if (prep_reg)
            begin
                if (zero_reg || (mag_reg >= span_reg))
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg && (cnt_reg == 5'd1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg  <= offset[32];
            mag_reg  <= offset[32] ? 33'(-offset) : 33'(offset);
            zero_reg <= span[32] || (span == 33'sd0);
            span_reg <= 33'(span);
        end
        if (prep_reg)
        begin
            // quotient at least one saturates straight away; a span not above zero gives zero
            if (zero_reg)
            begin
                alpha_reg <= 18'sd0;
            end
            else if (mag_reg >= span_reg)
            begin
                alpha_reg <= neg_reg ? -ALPHA_ONE : ALPHA_ONE;
            end
            rem_reg <= mag_reg;
            q_reg   <= 16'd0;
            cnt_reg <= 5'(FRAC_BITS);
        end
        else if (busy_reg)
        begin
            // one restoring step per cycle
            rem_reg <= fits ? 33'(rem_shift - {1'b0, span_reg}) : rem_shift[32:0];
            q_reg   <= {q_reg[14:0], fits};
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                alpha_reg <= neg_reg ? -$signed({2'b00, q_reg[14:0], fits})
                                     : $signed({2'b00, q_reg[14:0], fits});
            end
        end
    end

endmodule

FILE: rtl/plsl_back.sv
module plsl_back
    import plsl_pkg::*;
#(
    parameter int MAX_KEYS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_take,
    input  plsl_cmd_t          cmd,
    input  logic [6:0]         key_count,
    input  logic               wrap_mode,
    output logic               empty,
    input  logic               pop,
    output logic [5:0]         first_index,
    output logic [5:0]         second_index,
    output logic signed [17:0] alpha
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = (AW > 7 ? AW : 7) + 1;

    logic signed [31:0] mem [MAX_KEYS];
    logic signed [31:0] rdata_reg;
    logic [AW-1:0]      raddr;
    logic               wr_en;

    plsl_state_t        state_reg, state_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] prev_reg, prev_next;
    logic signed [31:0] k0_reg, k0_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [5:0]         i0_reg, i0_next;
    logic [5:0]         i1_reg, i1_next;
    logic signed [17:0] apend_reg, apend_next;
    logic               out_valid_reg, out_valid_next;
    logic [5:0]         first_reg;
    logic [5:0]         second_reg;
    logic signed [17:0] alpha_reg;
    logic               out_free;
    logic               load_out;
    logic [CW-1:0]      n_calc;
    logic [AW-1:0]      last_addr;
    logic               div_start;
    logic signed [32:0] div_offset;
    logic signed [32:0] div_span;
    logic               div_done;
    logic signed [17:0] div_alpha;

    plsl_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .offset (div_offset),
        .span   (div_span),
        .done   (div_done),
        .alpha  (div_alpha)
    );

    assign out_free     = !out_valid_reg || pop;
    assign empty        = !out_valid_reg;
    assign first_index  = first_reg;
    assign second_index = second_reg;
    assign alpha        = alpha_reg;
    assign last_addr    = AW'(n_reg - CW'(1));

    always_comb
    begin
        if (key_count == 7'd0)
        begin
            n_calc = CW'(1);
        end
        else if (CW'(key_count) > CW'(MAX_KEYS))
        begin
            n_calc = CW'(MAX_KEYS);
        end
        else
        begin
            n_calc = CW'(key_count);
        end
    end

    always_comb
    begin
        case (state_reg)
            BK_RDL:  raddr = last_addr;
            BK_SRD:  raddr = i_reg + AW'(1);
            default: raddr = '0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        prev_next  = prev_reg;
        k0_next    = k0_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        i0_next    = i0_reg;
        i1_next    = i1_reg;
        apend_next = apend_reg;
        cmd_take   = 1'b0;
        wr_en      = 1'b0;
        div_start  = 1'b0;
        div_offset = 33'sd0;
        div_span   = 33'sd0;
        load_out   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    if (!cmd.lookup)
                    begin
                        wr_en = (CW'(cmd.index) < CW'(MAX_KEYS));
                    end
                    else
                    begin
                        x_next = cmd.value;
                        n_next = n_calc;
                        if (n_calc == CW'(1))
                        begin
                            i0_next    = 6'd0;
                            i1_next    = 6'd0;
                            apend_next = 18'sd0;
                            state_next = BK_RES;
                        end
                        else
                        begin
                            state_next = BK_RD0;
                        end
                    end
                end
            end
            BK_RD0:
            begin
                state_next = BK_RDL;
            end
            BK_RDL:
            begin
                k0_next    = rdata_reg;
                state_next = BK_CHK;
            end
            BK_CHK:
            begin
                // rdata_reg holds the last key here
                apend_next = 18'sd0;
                if (x_reg < k0_reg)
                begin
                    if (wrap_mode)
                    begin
                        i0_next    = 6'(last_addr);
                        i1_next    = 6'd0;
                        div_start  = 1'b1;
                        div_offset = 33'(x_reg);
                        div_span   = 33'(k0_reg);
                        state_next = BK_DIV;
                    end
                    else
                    begin
                        i0_next    = 6'd0;
                        i1_next    = 6'd0;
                        state_next = BK_RES;
                    end
                end
                else if (x_reg >= rdata_reg)
                begin
                    i0_next = 6'(last_addr);
                    if (wrap_mode)
                    begin
                        i1_next    = 6'd0;
                        div_start  = 1'b1;
                        div_offset = 33'(x_reg) - 33'(rdata_reg);
                        div_span   = 33'(k0_reg);
                        state_next = BK_DIV;
                    end
                    else
                    begin
                        i1_next    = 6'(last_addr);
                        state_next = BK_RES;
                    end
                end
                else
                begin
                    prev_next  = k0_reg;
                    i_next     = '0;
                    state_next = BK_SRD;
                end
            end
            BK_SRD:
            begin
                state_next = BK_SCMP;
            end
            BK_SCMP:
            begin
                // rdata_reg holds key i+1, prev_reg key i
                if ((x_reg < rdata_reg) || ((CW'(i_reg) + CW'(2)) >= n_reg))
                begin
                    i0_next    = 6'(i_reg);
                    i1_next    = 6'(i_reg) + 6'd1;
                    div_start  = 1'b1;
                    div_offset = 33'(x_reg) - 33'(prev_reg);
                    div_span   = 33'(rdata_reg) - 33'(prev_reg);
                    state_next = BK_DIV;
                end
                else
                begin
                    prev_next  = rdata_reg;
                    i_next     = i_reg + AW'(1);
                    state_next = BK_SRD;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    apend_next = div_alpha;
                    state_next = BK_RES;
                end
            end
            BK_RES:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        prev_reg  <= prev_next;
        k0_reg    <= k0_next;
        n_reg     <= n_next;
        i_reg     <= i_next;
        i0_reg    <= i0_next;
        i1_reg    <= i1_next;
        apend_reg <= apend_next;
        if (load_out)
        begin
            first_reg  <= i0_reg;
            second_reg <= i1_reg;
            alpha_reg  <= apend_reg;
        end
    end

    // key table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(cmd.index)] <= cmd.value;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

FILE: rtl/piecewise_linear_segment_lookup_unit.sv
// piecewise-linear segment lookup
// input queue side: push/full, a word is taken when push is high and full low;
//   opcode selects key write (key_index, key_value) or lookup (lookup_key)
// result queue side: empty/pop, the oldest result sits on first_index,
//   second_index and alpha while empty is low and leaves on pop
// config: apb port, key_count at 0x0, wrap_mode at 0x4, pready tied high
// a two-word front queue classifies incoming words; the back part owns the
//   key table memory, walks it one key at a time and, where needed, runs a
//   restoring divider that yields one quotient bit per cycle
// a key write is stored by the back part as it is taken; a lookup fetches
//   the first and last keys, steps over the keys below its segment and
//   then divides where a blend is needed
// one word is worked on at a time; the front queue keeps taking words while
//   the back part is busy and full rises once it holds two
// a result waits in the output register while pop is low; the back part
//   stalls on the next result until that register is freed
// reset empties both queues, sets key_count to 1 and wrap_mode to 0;
//   the key table is not cleared and must be written before use
module piecewise_linear_segment_lookup_unit
    import plsl_pkg::*;
#(
    parameter int MAX_KEYS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input word queue
    input  logic               push,
    output logic               full,
    input  logic               opcode,
    input  logic [5:0]         key_index,
    input  logic signed [31:0] key_value,
    input  logic signed [31:0] lookup_key,
    // result word queue
    output logic               empty,
    input  logic               pop,
    output logic [5:0]         first_index,
    output logic [5:0]         second_index,
    output logic signed [17:0] alpha,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [6:0] key_count_reg;
    logic       wrap_mode_reg;
    logic       cfg_wr;
    logic       cmd_valid;
    logic       cmd_take;
    plsl_cmd_t  cmd;

    // register file, address bit 2 picks the register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_KEY_COUNT: prdata = {25'd0, key_count_reg};
            REG_WRAP_MODE: prdata = {31'd0, wrap_mode_reg};
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= 7'd1;
            wrap_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_KEY_COUNT)
            begin
                key_count_reg <= pwdata[6:0];
            end
            else
            begin
                wrap_mode_reg <= pwdata[0];
            end
        end
    end

    // front: accept and classify words
    plsl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .key_index  (key_index),
        .key_value  (key_value),
        .lookup_key (lookup_key),
        .cmd_valid  (cmd_valid),
        .cmd_take   (cmd_take),
        .cmd        (cmd)
    );

    // back: table, segment search, divider, result register
    plsl_back #(
        .MAX_KEYS (MAX_KEYS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_take     (cmd_take),
        .cmd          (cmd),
        .key_count    (key_count_reg),
        .wrap_mode    (wrap_mode_reg),
        .empty        (empty),
        .pop          (pop),
        .first_index  (first_index),
        .second_index (second_index),
        .alpha        (alpha)
    );

    // blend factor stays saturated to plus or minus one
    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((alpha <= ALPHA_ONE) && (alpha >= -ALPHA_ONE)))
        else $error("alpha out of range");

    // a segment is either a single key, adjacent keys or the wrap pair
    a_segment_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (first_index != second_index)) |->
            ((second_index == first_index + 6'd1) || (second_index == 6'd0)))
        else $error("bad segment indices");

    // a word is never taken from the front queue while it is empty
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid)
        else $error("take from empty front queue");

endmodule

FILE: tb/tb_piecewise_linear_segment_lookup_unit.sv
module tb_piecewise_linear_segment_lookup_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import plsl_pkg::*;

    localparam int NUM_KEYS   = 64;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN_WAIT = 200;

    // register byte addresses
    localparam logic [2:0] ADDR_KEY_COUNT = 3'(4 * REG_KEY_COUNT);
    localparam logic [2:0] ADDR_WRAP_MODE = 3'(4 * REG_WRAP_MODE);

    typedef struct packed {
        logic [5:0]         first_idx;
        logic [5:0]         second_idx;
        logic signed [17:0] blend;
    } segment_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic               opcode;
    logic [5:0]         key_index;
    logic signed [31:0] key_value;
    logic signed [31:0] lookup_key;
    logic               empty;
    logic               pop;
    logic [5:0]         first_index;
    logic [5:0]         second_index;
    logic signed [17:0] alpha;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    piecewise_linear_segment_lookup_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .opcode       (opcode),
        .key_index    (key_index),
        .key_value    (key_value),
        .lookup_key   (lookup_key),
        .empty        (empty),
        .pop          (pop),
        .first_index  (first_index),
        .second_index (second_index),
        .alpha        (alpha),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // shadow of the block's state
    logic signed [31:0] curve_keys [NUM_KEYS];
    logic [6:0]         shadow_count;
    logic               shadow_wrap;

    segment_t segments_due [$];
    int       mismatches;
    int       stall_cycles;
    bit       timed_out;
    bit       push_idle_on;
    bit       pop_idle_on;

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // offset / span in q1.16, truncated toward zero, saturated, zero on bad span
    function automatic logic signed [17:0] blend_of(longint offset, longint span);
        longint q;
        if (span <= 0)
            return '0;
        q = (offset * 65536) / span;
        if (q > 65536)
            q = 65536;
        if (q < -65536)
            q = -65536;
        return 18'(q);
    endfunction

    function automatic int live_keys();
        int n;
        n = shadow_count;
        if (n < 1)
            n = 1;
        if (n > NUM_KEYS)
            n = NUM_KEYS;
        return n;
    endfunction

    // segment search on the shadow table
    function automatic segment_t find_segment(logic signed [31:0] pos);
        segment_t s;
        int       n;
        int       i;
        longint   x;
        longint   k0;
        longint   kl;
        n = live_keys();
        x = pos;
        s = '0;
        if (n > 1)
        begin
            k0 = curve_keys[0];
            kl = curve_keys[n - 1];
            if (x < k0)
            begin
                if (shadow_wrap)
                begin
                    s.first_idx = 6'(n - 1);
                    s.blend     = blend_of(x, k0);
                end
            end
            else if (x >= kl)
            begin
                s.first_idx = 6'(n - 1);
                if (shadow_wrap)
                    s.blend = blend_of(x - kl, k0);
                else
                    s.second_idx = 6'(n - 1);
            end
            else
            begin
                i = 0;
                while (i + 2 < n && !(x < longint'(curve_keys[i + 1])))
                    i++;
                s.first_idx  = 6'(i);
                s.second_idx = 6'(i + 1);
                s.blend      = blend_of(x - curve_keys[i],
                                        longint'(curve_keys[i + 1]) - curve_keys[i]);
            end
        end
        return s;
    endfunction

    // random lookup position: near keys, at keys, or anywhere
    function automatic logic signed [31:0] pick_position();
        int n;
        int j;
        n = live_keys();
        j = $urandom_range(n - 1, 0);
        case ($urandom_range(3, 0))
            0: return $urandom;
            1: return curve_keys[j];
            default: return curve_keys[j] + 32'($signed(12'($urandom)));
        endcase
    endfunction

    // one input word; waits for acceptance and leaves push high,
    // the next word or wait_idle drops it
    task automatic send_word(logic op, logic [5:0] idx, logic signed [31:0] kv,
                             logic signed [31:0] pos);
        while (push_idle_on && $urandom_range(99, 0) < 9)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        opcode     <= op;
        key_index  <= idx;
        key_value  <= kv;
        lookup_key <= pos;
        do
            @(posedge clk);
        while (full);
        if (op == OP_WRITE)
            curve_keys[idx] = kv;
        else
            segments_due.push_back(find_segment(pos));
        @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // waits until every result is back, then lets the last key write settle
    task automatic wait_idle();
        push <= 1'b0;
        while (segments_due.size() != 0 && !timed_out)
            @(negedge clk);
        repeat (8)
            @(negedge clk);
    endtask

    task automatic set_mode(logic [6:0] count, logic wrap);
        wait_idle();
        write_reg(ADDR_KEY_COUNT, 32'(count));
        write_reg(ADDR_WRAP_MODE, 32'(wrap));
        shadow_count = count;
        shadow_wrap  = wrap;
    endtask

    // ascending table with a random start and random steps
    task automatic load_ascending(int n, int max_step);
        logic signed [31:0] v;
        v = $urandom_range(200000, 0) - 100000;
        for (int i = 0; i < n; i++)
        begin
            send_word(OP_WRITE, 6'(i), v, $urandom);
            v = v + $urandom_range(max_step, 1);
        end
    endtask

    task automatic test_directed();
        // single key, then extremes of a two-key table in both modes
        send_word(OP_WRITE, 6'd0, 32'sh0001_0000, $urandom);
        send_word(OP_LOOKUP, 6'($urandom), $urandom, 32'sh7fff_ffff);
        send_word(OP_WRITE, 6'd1, 32'sh0003_0000, $urandom);
        set_mode(7'd2, 1'b0);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sh8000_0000);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sh0001_8000);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sh0003_0000);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sh7fff_ffff);
        set_mode(7'd2, 1'b1);
        send_word(OP_LOOKUP, 6'h3f, 32'hffff_ffff, 32'sh8000_0000);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sh0000_8000);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sh0003_4000);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sh7fff_ffff);
        // first key not positive: wrap blend is zero
        send_word(OP_WRITE, 6'd0, 32'sh8000_0000, $urandom);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sh7fff_ffff);
        send_word(OP_WRITE, 6'd0, 32'sd0, $urandom);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sh7000_0000);
        // keys out of order and a flat span
        send_word(OP_WRITE, 6'd2, 32'sh7fff_ffff, $urandom);
        send_word(OP_WRITE, 6'd1, 32'sd0, $urandom);
        set_mode(7'd3, 1'b0);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sd0);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sh1234_5678);
        // zero count acts as one, excess count as the full table
        set_mode(7'd0, 1'b1);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, 32'sh0000_0001);
        load_ascending(NUM_KEYS, 32'sh0100_0000);
        set_mode(7'd127, 1'b0);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, curve_keys[62] + 1);
        send_word(OP_LOOKUP, 6'd0, 32'sd0, curve_keys[63]);
    endtask

    task automatic test_random();
        int                 n;
        logic signed [31:0] kv;
        for (int phase = 0; phase < 12; phase++)
        begin
            // keep most tables short; full table now and then
            n = (phase % 4 == 3) ? NUM_KEYS : $urandom_range(12, 2);
            push_idle_on = (phase != 5);
            pop_idle_on  = (phase != 5);
            load_ascending(n, (phase % 2) ? 32'h7fff : 32'h03ff_ffff);
            set_mode(7'(n), phase[0]);
            for (int k = 0; k < 60; k++)
            begin
                if ($urandom_range(9, 0) == 0)
                begin
                    // noise: overwrite a live key with anything
                    kv = (k % 3 == 0) ? $urandom : curve_keys[$urandom_range(n - 1, 0)] + 7;
                    send_word(OP_WRITE, 6'($urandom_range(n - 1, 0)), kv, $urandom);
                end
                else
                    send_word(OP_LOOKUP, 6'($urandom), $urandom, pick_position());
            end
        end
    endtask

    // result side: random pops, compare against the oldest prediction
    always @(posedge clk)
    begin
        segment_t want;
        if (rst_n && pop && !empty)
        begin
            if (segments_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %0d %0d %0d",
                             first_index, second_index, alpha);
            end
            else
            begin
                want = segments_due.pop_front();
                if (first_index !== want.first_idx || second_index !== want.second_idx
                    || alpha !== want.blend)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                 want.first_idx, want.second_idx, want.blend,
                                 first_index, second_index, alpha);
                end
            end
        end
    end

    always @(negedge clk)
        pop <= rst_n && !(pop_idle_on && $urandom_range(99, 0) < 9);

    // watchdog on cycles with no word pushed or popped
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            timed_out = 1'b1;
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        opcode       = OP_WRITE;
        key_index    = '0;
        key_value    = '0;
        lookup_key   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        mismatches   = 0;
        stall_cycles = 0;
        timed_out    = 1'b0;
        push_idle_on = 1'b1;
        pop_idle_on  = 1'b1;
        shadow_count = 7'd1;
        shadow_wrap  = 1'b0;
        foreach (curve_keys[i])
            curve_keys[i] = '0;
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        wait_idle();
        repeat (DRAIN_WAIT)
            @(negedge clk);
        if (mismatches == 0 && segments_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
